/* design/vlcm_pkg.sv */
// Package for the vector lane compare unit: operand kinds, predicate codes,
// and the stage-to-stage flag struct. No dependencies.
package vlcm_pkg;

   typedef enum logic [2:0] {
      KIND_I16 = 3'd0, KIND_U16 = 3'd1, KIND_I32 = 3'd2, KIND_U32 = 3'd3,
      KIND_I64 = 3'd4, KIND_U64 = 3'd5, KIND_F32 = 3'd6, KIND_F64 = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      PR_F = 4'd0, PR_LT = 4'd1, PR_EQ = 4'd2, PR_LE = 4'd3,
      PR_GT = 4'd4, PR_LG = 4'd5, PR_GE = 4'd6, PR_O = 4'd7,
      PR_U = 4'd8, PR_NGE = 4'd9, PR_NLG = 4'd10, PR_NGT = 4'd11,
      PR_NLE = 4'd12, PR_NEQ = 4'd13, PR_NLT = 4'd14, PR_TRU = 4'd15
   } pred_type;

   // Order flags from the compare stage.
   typedef struct packed {
      logic lt;
      logic eq;
      logic gt;
      logic un;
   } order_type;

endpackage

/* design/vlcm_req_if.sv */
// Request and response channel interfaces for the lane compare unit.
// Depends on nothing.
interface vlcm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] src0;
   logic [63:0] src1;
   logic [2:0]  operand_kind;
   logic [3:0]  req_type;
   logic        write_exec;
   logic        lane_active;
   logic        old_mask_bit;
   logic        old_exec_bit;
   modport source (output valid, src0, src1, operand_kind, req_type, write_exec,
                   lane_active, old_mask_bit, old_exec_bit, input ready);
   modport sink (input valid, src0, src1, operand_kind, req_type, write_exec,
                 lane_active, old_mask_bit, old_exec_bit, output ready);
endinterface

interface vlcm_rsp_if;
   logic valid;
   logic ready;
   logic mask_bit;
   logic exec_bit;
   logic unsupported;
   modport source (output valid, mask_bit, exec_bit, unsupported, input ready);
   modport sink (input valid, mask_bit, exec_bit, unsupported, output ready);
endinterface

/* design/vlcm_order.sv */
// Order compare of two operands per kind: integer and IEEE float flags.
// Depends on vlcm_pkg.
module vlcm_order (
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   input  logic [2:0]          kind,
   output vlcm_pkg::order_type order
);
   logic [63:0] x, y;
   logic        fa_nan, fb_nan, a_zero, b_zero, is_float, un;
   logic        f_lt, f_eq, i_lt, i_eq, a_neg, b_neg, mag_lt, mag_eq;

   always_comb begin
      x        = a;
      y        = b;
      is_float = 1'b0;
      fa_nan   = 1'b0;
      fb_nan   = 1'b0;
      a_zero   = 1'b0;
      b_zero   = 1'b0;
      a_neg    = 1'b0;
      b_neg    = 1'b0;
      case (kind)
         vlcm_pkg::KIND_I16, vlcm_pkg::KIND_U16: begin
            x = {48'd0, a[15:0]};
            y = {48'd0, b[15:0]};
            if (kind == vlcm_pkg::KIND_I16) begin
               x[15] = ~x[15];
               y[15] = ~y[15];
            end
         end
         vlcm_pkg::KIND_I32, vlcm_pkg::KIND_U32: begin
            x = {32'd0, a[31:0]};
            y = {32'd0, b[31:0]};
            if (kind == vlcm_pkg::KIND_I32) begin
               x[31] = ~x[31];
               y[31] = ~y[31];
            end
         end
         vlcm_pkg::KIND_I64: begin
            x[63] = ~a[63];
            y[63] = ~b[63];
         end
         vlcm_pkg::KIND_F32: begin
            // Sign-magnitude compare on the 31 magnitude bits.
            is_float = 1'b1;
            x      = {33'd0, a[30:0]};
            y      = {33'd0, b[30:0]};
            a_neg  = a[31];
            b_neg  = b[31];
            fa_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
            fb_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
            a_zero = (a[30:0] == 31'd0);
            b_zero = (b[30:0] == 31'd0);
         end
         vlcm_pkg::KIND_F64: begin
            is_float = 1'b1;
            x      = {1'b0, a[62:0]};
            y      = {1'b0, b[62:0]};
            a_neg  = a[63];
            b_neg  = b[63];
            fa_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
            fb_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
            a_zero = (a[62:0] == 63'd0);
            b_zero = (b[62:0] == 63'd0);
         end
         default: begin
            x = a;
            y = b;
         end
      endcase
   end

   assign mag_lt = x < y;
   assign mag_eq = x == y;
   assign i_lt   = mag_lt;
   assign i_eq   = mag_eq;

   // Float ordering; both zeros equal regardless of sign.
   always_comb begin
      if (a_zero && b_zero) begin
         f_eq = 1'b1;
         f_lt = 1'b0;
      end else begin
         f_eq = mag_eq && (a_neg == b_neg);
         case ({a_neg, b_neg})
            2'b00:   f_lt = mag_lt;
            2'b11:   f_lt = !mag_lt && !mag_eq;
            2'b10:   f_lt = 1'b1;
            default: f_lt = 1'b0;
         endcase
      end
   end

   assign un = is_float && (fa_nan || fb_nan);

   always_comb begin
      if (is_float) begin
         order.un = un;
         order.lt = !un && f_lt;
         order.eq = !un && f_eq;
         order.gt = !un && !f_lt && !f_eq;
      end else begin
         order.un = 1'b0;
         order.lt = i_lt;
         order.eq = i_eq;
         order.gt = !i_lt && !i_eq;
      end
   end
endmodule

/* design/vector_lane_compare_mask.sv */
// Lane compare unit: an accepted word's result is registered in the result
// register. Throughput one word per cycle; the result register advances
// whenever it is empty or being taken.
// Reset (synchronous, active high) empties the result register.
// Depends on vlcm_pkg, vlcm_req_if, vlcm_rsp_if, vlcm_order.
module vector_lane_compare_mask (
   input logic       clock,
   input logic       reset,
   vlcm_req_if.sink  req,
   vlcm_rsp_if.source rsp
);
   vlcm_pkg::order_type order;
   logic valid_ff, valid_in;
   logic mask_ff, mask_in, exec_ff, exec_in, unsup_ff, unsup_in;
   logic r, is_int_bad, accept;

   vlcm_order u_order (
      .a     (req.src0),
      .b     (req.src1),
      .kind  (req.operand_kind),
      .order (order)
   );

   assign req.ready = !valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Predicate select.
   always_comb begin
      case (vlcm_pkg::pred_type'(req.req_type))
         vlcm_pkg::PR_F:   r = 1'b0;
         vlcm_pkg::PR_LT:  r = order.lt;
         vlcm_pkg::PR_EQ:  r = order.eq;
         vlcm_pkg::PR_LE:  r = order.lt || order.eq;
         vlcm_pkg::PR_GT:  r = order.gt;
         vlcm_pkg::PR_LG:  r = order.lt || order.gt;
         vlcm_pkg::PR_GE:  r = order.gt || order.eq;
         vlcm_pkg::PR_O:   r = !order.un;
         vlcm_pkg::PR_U:   r = order.un;
         vlcm_pkg::PR_NGE: r = !(order.gt || order.eq);
         vlcm_pkg::PR_NLG: r = !(order.lt || order.gt);
         vlcm_pkg::PR_NGT: r = !order.gt;
         vlcm_pkg::PR_NLE: r = !(order.lt || order.eq);
         vlcm_pkg::PR_NEQ: r = !order.eq;
         vlcm_pkg::PR_NLT: r = !order.lt;
         default:          r = 1'b1;
      endcase
   end

   // Ordered, unordered and negated forms are float only.
   assign is_int_bad = !(req.operand_kind inside {vlcm_pkg::KIND_F32, vlcm_pkg::KIND_F64}) &&
                       (req.req_type inside {[vlcm_pkg::PR_O:vlcm_pkg::PR_NLT]});

   // Next result word.
   always_comb begin
      mask_in  = req.old_mask_bit;
      exec_in  = req.old_exec_bit;
      unsup_in = 1'b0;
      if (req.lane_active) begin
         if (is_int_bad) begin
            unsup_in = 1'b1;
         end else begin
            mask_in = r;
            if (req.write_exec) begin
               exec_in = r;
            end
         end
      end
      valid_in = accept || (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         mask_ff  <= mask_in;
         exec_ff  <= exec_in;
         unsup_ff <= unsup_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.mask_bit    = mask_ff;
   assign rsp.exec_bit    = exec_ff;
   assign rsp.unsupported = unsup_ff;

   // A held result must not change while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp.ready) |=> $stable({mask_ff, exec_ff, unsup_ff}))
      else $error("result changed while stalled");
   // Accept always fills the result register.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted word lost");
   // Unsupported never reports a changed bit.
   a_unsup: assert property (@(posedge clock) disable iff (reset)
      (accept && unsup_in) |-> (mask_in == req.old_mask_bit &&
                               exec_in == req.old_exec_bit))
      else $error("unsupported word changed bits");
endmodule

/* verif/tb_top.sv */
// Testbench for vector_lane_compare_mask: drives random and directed compare words,
// predicts each lane result and checks it in order.
// Depends on vlcm_pkg, vlcm_req_if, vlcm_rsp_if and the block itself.
`timescale 1ns / 100ps

typedef struct packed {
   logic mask_bit;
   logic exec_bit;
   logic unsupported;
} lane_result_type;

class lane_scoreboard;
   lane_result_type pending[$];
   int              errors;

   // True when the value is a NaN of the kind's width.
   function bit is_nan(logic [63:0] v, bit dbl);
      if (dbl) return v[62:52] == 11'h7ff && v[51:0] != 52'd0;
      return v[30:23] == 8'hff && v[22:0] != 23'd0;
   endfunction

   // Compare two floats held as raw bits; sign-magnitude ordering, zeros equal.
   function void float_order(logic [63:0] a, logic [63:0] b, bit dbl,
                             output bit lt, output bit eq, output bit un);
      logic [63:0] ma, mb;
      bit          sa, sb;
      if (dbl) begin
         sa = a[63]; sb = b[63];
         ma = {1'b0, a[62:0]}; mb = {1'b0, b[62:0]};
      end else begin
         sa = a[31]; sb = b[31];
         ma = {33'b0, a[30:0]}; mb = {33'b0, b[30:0]};
      end
      un = is_nan(a, dbl) || is_nan(b, dbl);
      lt = 1'b0; eq = 1'b0;
      if (un) return;
      if (ma == 64'd0 && mb == 64'd0) eq = 1'b1;
      else if (sa != sb) lt = sa;
      else if (ma == mb) eq = 1'b1;
      else lt = sa ? (ma > mb) : (ma < mb);
   endfunction

   // Note an accepted request and store its predicted lane result.
   function void note_request(logic [63:0] a, logic [63:0] b, vlcm_pkg::kind_type kind,
                              vlcm_pkg::pred_type pred, bit wexec, bit active,
                              bit om, bit oe);
      lane_result_type r;
      bit              lt, eq, gt, un, res;
      logic [63:0]     x, y;
      r = '{om, oe, 1'b0};
      if (active) begin
         un = 1'b0;
         if (kind == vlcm_pkg::KIND_F32 || kind == vlcm_pkg::KIND_F64) begin
            float_order(a, b, kind == vlcm_pkg::KIND_F64, lt, eq, un);
            gt = !un && !lt && !eq;
         end else if (pred inside {[vlcm_pkg::PR_O:vlcm_pkg::PR_NLT]}) begin
            r.unsupported = 1'b1;
         end else begin
            case (kind)
               vlcm_pkg::KIND_I16, vlcm_pkg::KIND_U16: begin
                  x = {48'd0, a[15:0]}; y = {48'd0, b[15:0]};
               end
               vlcm_pkg::KIND_I32, vlcm_pkg::KIND_U32: begin
                  x = {32'd0, a[31:0]}; y = {32'd0, b[31:0]};
               end
               default: begin x = a; y = b; end
            endcase
            if (kind == vlcm_pkg::KIND_I16) begin x[15] ^= 1'b1; y[15] ^= 1'b1; end
            if (kind == vlcm_pkg::KIND_I32) begin x[31] ^= 1'b1; y[31] ^= 1'b1; end
            if (kind == vlcm_pkg::KIND_I64) begin x[63] ^= 1'b1; y[63] ^= 1'b1; end
            lt = x < y; eq = x == y; gt = !lt && !eq;
         end
         if (!r.unsupported) begin
            case (pred)
               vlcm_pkg::PR_F:   res = 1'b0;
               vlcm_pkg::PR_LT:  res = lt;
               vlcm_pkg::PR_EQ:  res = eq;
               vlcm_pkg::PR_LE:  res = lt || eq;
               vlcm_pkg::PR_GT:  res = gt;
               vlcm_pkg::PR_LG:  res = lt || gt;
               vlcm_pkg::PR_GE:  res = gt || eq;
               vlcm_pkg::PR_O:   res = !un;
               vlcm_pkg::PR_U:   res = un;
               vlcm_pkg::PR_NGE: res = !(gt || eq);
               vlcm_pkg::PR_NLG: res = !(lt || gt);
               vlcm_pkg::PR_NGT: res = !gt;
               vlcm_pkg::PR_NLE: res = !(lt || eq);
               vlcm_pkg::PR_NEQ: res = !eq;
               vlcm_pkg::PR_NLT: res = !lt;
               default: res = 1'b1;
            endcase
            r.mask_bit = res;
            if (wexec) r.exec_bit = res;
         end
      end
      pending.push_back(r);
   endfunction

   // Check one accepted response against the oldest prediction.
   function void check_response(lane_result_type got);
      lane_result_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %b", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.mask_bit !== want.mask_bit) begin
         $display("%0t: mask_bit expected %b actual %b", $time, want.mask_bit, got.mask_bit);
         errors++;
      end
      if (got.exec_bit !== want.exec_bit) begin
         $display("%0t: exec_bit expected %b actual %b", $time, want.exec_bit, got.exec_bit);
         errors++;
      end
      if (got.unsupported !== want.unsupported) begin
         $display("%0t: unsupported expected %b actual %b", $time, want.unsupported,
                  got.unsupported);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int STALL_LIMIT = 2000;

   logic clock;
   logic reset;
   int   idle_cycles;
   bit   stim_done;

   vlcm_req_if req_ch ();
   vlcm_rsp_if rsp_ch ();

   vector_lane_compare_mask dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   lane_scoreboard lanes = new();

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Interesting operand values: zeros, extremes, infinities, NaNs.
   logic [63:0] corner_vals[] = '{
      64'h0, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
      64'h8000, 64'h7fff, 64'h8000_0000, 64'h7fff_ffff, 64'h3f80_0000, 64'hbf80_0000,
      64'h7f80_0000, 64'hff80_0000, 64'h7fc0_0000, 64'h7f80_0001,
      64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000, 64'h7ff0_0000_0000_0000,
      64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000, 64'h7ff0_0000_0000_0001,
      64'h1, 64'h1234_5678_0000_0001};

   function logic [63:0] pick_operand();
      case ($urandom_range(0, 3))
         0: return corner_vals[$urandom_range(0, corner_vals.size() - 1)];
         1: return {$urandom, $urandom};
         2: return {$urandom, $urandom} ^ (64'h1 << $urandom_range(0, 63));
         default: return $urandom_range(0, 3) ? {32'h0, $urandom} : {$urandom, 32'h0};
      endcase
   endfunction

   // Send one word, waiting a random gap first unless quiet, and hold until accepted.
   task automatic send_word(logic [63:0] a, logic [63:0] b, vlcm_pkg::kind_type kind,
                            vlcm_pkg::pred_type pred, bit wexec, bit active, bit om,
                            bit oe, bit quiet);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.src0 <= a;
      req_ch.src1 <= b;
      req_ch.operand_kind <= kind;
      req_ch.req_type <= pred;
      req_ch.write_exec <= wexec;
      req_ch.lane_active <= active;
      req_ch.old_mask_bit <= om;
      req_ch.old_exec_bit <= oe;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      lanes.note_request(a, b, kind, pred, wexec, active, om, oe);
   endtask

   // Response side: random stalls per word, with quiet stretches.
   initial begin
      int wait_n;
      bit quiet;
      rsp_ch.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         quiet = ($urandom_range(0, 99) < 20);
         repeat (quiet ? 40 : 1) begin
            wait_n = quiet ? 0 : $urandom_range(0, 14);
            if (wait_n > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (wait_n) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
            while (!rsp_ch.valid) @(posedge clock);
            lanes.check_response('{rsp_ch.mask_bit, rsp_ch.exec_bit, rsp_ch.unsupported});
         end
      end
   end

   // Watchdog on cycles with no accepted word on either side.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (stim_done && lanes.pending.size() == 0))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Stimulus: directed corners, then random words.
   initial begin
      bit quiet;
      int burst;
      reset = 1'b1;
      stim_done = 1'b0;
      idle_cycles = 0;
      req_ch.valid = 1'b0;
      req_ch.src0 = 64'd0;
      req_ch.src1 = 64'd0;
      req_ch.operand_kind = vlcm_pkg::KIND_I16;
      req_ch.req_type = vlcm_pkg::PR_F;
      req_ch.write_exec = 1'b0;
      req_ch.lane_active = 1'b0;
      req_ch.old_mask_bit = 1'b0;
      req_ch.old_exec_bit = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every predicate on the signed 16-bit kind, plus float, inactive and zero cases.
      for (int p = 0; p < 16; p++)
         send_word(64'hffff, 64'h1, vlcm_pkg::KIND_I16, vlcm_pkg::pred_type'(p),
                   p[0], 1'b1, p[1], p[2], 1'b0);
      send_word(64'h7fc0_0000, 64'h3f80_0000, vlcm_pkg::KIND_F32, vlcm_pkg::PR_U,
                1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_word(64'h7fc0_0000, 64'h3f80_0000, vlcm_pkg::KIND_F32, vlcm_pkg::PR_NEQ,
                1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_word(64'h8000_0000, 64'h0, vlcm_pkg::KIND_F32, vlcm_pkg::PR_EQ,
                1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
      send_word(64'h8000_0000_0000_0000, 64'h0, vlcm_pkg::KIND_F64, vlcm_pkg::PR_EQ,
                1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      send_word(64'h7ff8_0000_0000_0000, 64'h0, vlcm_pkg::KIND_F64, vlcm_pkg::PR_O,
                1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
      send_word(64'hffff_ffff_ffff_ffff, 64'h0, vlcm_pkg::KIND_U64, vlcm_pkg::PR_GT,
                1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_word(64'hffff_ffff_ffff_ffff, 64'h0, vlcm_pkg::KIND_I64, vlcm_pkg::PR_LT,
                1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_word(64'h1, 64'h0, vlcm_pkg::KIND_U32, vlcm_pkg::PR_NLT,
                1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      send_word(64'h1, 64'h0, vlcm_pkg::KIND_U32, vlcm_pkg::PR_LT,
                1'b1, 1'b0, 1'b1, 1'b0, 1'b0);

      for (int n = 0; n < 450; n += burst) begin
         quiet = ($urandom_range(0, 99) < 15);
         burst = quiet ? 30 : 1;
         repeat (burst)
            send_word(pick_operand(), $urandom_range(0, 4) ? pick_operand() : req_ch.src0,
                      vlcm_pkg::kind_type'($urandom_range(0, 7)),
                      vlcm_pkg::pred_type'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 5) != 0,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), quiet);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;

      while (lanes.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (lanes.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

/* vector_lane_compare_mask.f */
design/vlcm_pkg.sv
design/vlcm_req_if.sv
design/vlcm_order.sv
design/vector_lane_compare_mask.sv
verif/tb_top.sv
